### rtl/b58_pkg.sv
package b58_pkg;

   localparam int VALUE_W    = 64;
   localparam int SIZE_W     = 4;
   localparam int CHAR_W     = 7;
   localparam int POS_W      = 4;
   localparam int RADIX      = 58;
   localparam int HALF_RADIX = RADIX / 2;
   localparam int MAX_BYTES  = 8;
   localparam int MAX_CHARS  = 11;
   localparam int DIGIT_W    = 6;
   // input bits folded into the digit row per cycle
   localparam int GROUP_W    = 6;
   localparam int MAX_GROUPS = 12;
   localparam int SRC_W      = GROUP_W * MAX_GROUPS;
   localparam int SHAMT_W    = 7;
   localparam int ROW_W      = DIGIT_W * MAX_CHARS;

   // controls for one conversion cell
   typedef struct packed {
      logic clr;
      logic step;
   } cell_ctl_type;

   // controls for one output cell
   typedef struct packed {
      logic load;
      logic shift;
   } out_ctl_type;

   // block size clipped to the legal range top
   function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_W-1:0] size);
      if (size > SIZE_W'(MAX_BYTES)) begin
         return SIZE_W'(MAX_BYTES);
      end
      return size;
   endfunction

   // characters produced for a block size
   function automatic logic [POS_W-1:0] chars_for_size(input logic [SIZE_W-1:0] size);
      logic [POS_W-1:0] n;
      case (size)
         4'd1:    n = 4'd2;
         4'd2:    n = 4'd3;
         4'd3:    n = 4'd5;
         4'd4:    n = 4'd6;
         4'd5:    n = 4'd7;
         4'd6:    n = 4'd9;
         4'd7:    n = 4'd10;
         4'd8:    n = 4'd11;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // bit groups to fold in: ceil(8 * size / GROUP_W)
   function automatic logic [POS_W-1:0] steps_for_size(input logic [SIZE_W-1:0] size);
      logic [POS_W-1:0] n;
      case (size)
         4'd1:    n = 4'd2;
         4'd2:    n = 4'd3;
         4'd3:    n = 4'd4;
         4'd4:    n = 4'd6;
         4'd5:    n = 4'd7;
         4'd6:    n = 4'd8;
         4'd7:    n = 4'd10;
         4'd8:    n = 4'd11;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // keep only the low size bytes
   function automatic logic [VALUE_W-1:0] mask_value(input logic [VALUE_W-1:0] value,
                                                     input logic [SIZE_W-1:0] size);
      logic [VALUE_W-1:0] m;
      m = '0;
      for (int b = 0; b < MAX_BYTES; b++) begin
         if (SIZE_W'(b) < size) begin
            m[b*8 +: 8] = value[b*8 +: 8];
         end
      end
      return m;
   endfunction

   // left-align the value so its top bit group sits at the top of the source word
   function automatic logic [SRC_W-1:0] align_src(input logic [VALUE_W-1:0] value,
                                                  input logic [POS_W-1:0] steps);
      logic [SHAMT_W-1:0] sh;
      sh = SHAMT_W'(SRC_W - GROUP_W * int'(steps));
      return {{(SRC_W-VALUE_W){1'b0}}, value} << sh;
   endfunction

   // digit to alphabet character
   function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] dx;
      dx = CHAR_W'(d);
      case (d) inside
         [6'd0:6'd8]:   c = 7'd49 + dx;                 // '1'..'9'
         [6'd9:6'd16]:  c = 7'd65 + (dx - 7'd9);        // 'A'..'H'
         [6'd17:6'd21]: c = 7'd74 + (dx - 7'd17);       // 'J'..'N'
         [6'd22:6'd32]: c = 7'd80 + (dx - 7'd22);       // 'P'..'Z'
         [6'd33:6'd43]: c = 7'd97 + (dx - 7'd33);       // 'a'..'k'
         [6'd44:6'd57]: c = 7'd109 + (dx - 7'd44);      // 'm'..'z'
         default:       c = 7'd49;
      endcase
      return c;
   endfunction

endpackage

### rtl/b58_cell.sv
module b58_cell (
   input  logic                          clock,
   input  b58_pkg::cell_ctl_type         ctl,
   input  logic [b58_pkg::GROUP_W-1:0]   carry_in,
   output logic [b58_pkg::GROUP_W-1:0]   carry_out,
   output logic [b58_pkg::DIGIT_W-1:0]   digit_q,
   output logic [b58_pkg::DIGIT_W-1:0]   digit_next
);
   import b58_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] d;
   logic [DIGIT_W:0]   work;

   // one doubling per input bit, top bit first; carry out depends only on own digit
   always_comb begin
      d    = digit_ff;
      work = '0;
      for (int s = GROUP_W - 1; s >= 0; s--) begin
         carry_out[s] = (d >= DIGIT_W'(HALF_RADIX));
         work = {d, carry_in[s]};
         if (carry_out[s]) begin
            work = work - (DIGIT_W+1)'(RADIX);
         end
         d = work[DIGIT_W-1:0];
      end
      digit_next = d;
   end

   always_comb begin
      if (ctl.clr) begin
         digit_in = '0;
      end else if (ctl.step) begin
         digit_in = d;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_q = digit_ff;

endmodule

### rtl/b58_out_cell.sv
module b58_out_cell (
   input  logic                          clock,
   input  b58_pkg::out_ctl_type          ctl,
   input  logic [b58_pkg::DIGIT_W-1:0]   load_digit,
   input  logic [b58_pkg::DIGIT_W-1:0]   shift_in,
   output logic [b58_pkg::DIGIT_W-1:0]   digit_q
);
   import b58_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;

   // load a whole row, or pass the neighbor's digit up one place
   always_comb begin
      if (ctl.load) begin
         digit_in = load_digit;
      end else if (ctl.shift) begin
         digit_in = shift_in;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_q = digit_ff;

endmodule

### rtl/base58_block_encoder.sv
// A size-s block is folded into the digit row as ceil(8*s/6) bit groups (2 to 11);
// the finished row waits until the output row is free, is loaded into it, and its
// first character is offered. Throughput: one character per cycle while rsp_ready
// is high; an 8-byte block takes 11 fold steps; a new block folds while one is sent.
// Reset (synchronous, active high) empties the converter and the output row.
module base58_block_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [b58_pkg::VALUE_W-1:0]      req_block_value,
   input  logic [b58_pkg::SIZE_W-1:0]       req_block_size,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [b58_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic [b58_pkg::POS_W-1:0]        rsp_char_position,
   output logic                             rsp_last_char
);
   import b58_pkg::*;

   logic                 conv_busy_ff, conv_busy_in;
   logic                 conv_full_ff, conv_full_in;
   logic [POS_W-1:0]     steps_ff, steps_in;
   logic [POS_W-1:0]     chars_ff, chars_in;
   logic [SRC_W-1:0]     src_ff, src_in;
   logic [POS_W-1:0]     out_rem_ff, out_rem_in;
   logic [POS_W-1:0]     out_pos_ff, out_pos_in;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 conv_last_step;
   logic                 out_free;
   logic                 load_out;
   logic [SIZE_W-1:0]    size_eff;
   logic [POS_W-1:0]     req_steps;

   logic [GROUP_W-1:0]   carry [MAX_CHARS+1];
   logic [DIGIT_W-1:0]   cell_q [MAX_CHARS];
   logic [DIGIT_W-1:0]   cell_next [MAX_CHARS];
   logic [DIGIT_W-1:0]   out_q [MAX_CHARS];
   logic [ROW_W-1:0]     row_vec;
   logic [ROW_W-1:0]     row_aligned;
   logic [SHAMT_W-1:0]   row_shamt;
   cell_ctl_type         cell_ctl;
   out_ctl_type          out_ctl;

   // handshake and hand-over between the cell row and the output row
   assign conv_last_step = conv_busy_ff && (steps_ff == POS_W'(1));
   assign out_free       = (out_rem_ff == '0) || ((out_rem_ff == POS_W'(1)) && rsp_ready);
   assign load_out       = out_free && (conv_full_ff || conv_last_step);
   assign req_ready      = (!conv_busy_ff && !conv_full_ff) || load_out;
   assign req_xfer       = req_valid && req_ready;
   assign rsp_xfer       = rsp_valid && rsp_ready;

   assign size_eff  = size_sat(req_block_size);
   assign req_steps = steps_for_size(size_eff);

   // converter control
   always_comb begin
      conv_busy_in = conv_busy_ff;
      conv_full_in = conv_full_ff;
      steps_in     = steps_ff;
      chars_in     = chars_ff;
      src_in       = src_ff;
      if (load_out) begin
         conv_full_in = 1'b0;
      end else if (conv_last_step) begin
         conv_full_in = 1'b1;
      end
      if (conv_busy_ff) begin
         steps_in = steps_ff - POS_W'(1);
         src_in   = src_ff << GROUP_W;
         if (conv_last_step) begin
            conv_busy_in = 1'b0;
         end
      end
      if (req_xfer) begin
         conv_busy_in = (size_eff != '0);
         steps_in     = req_steps;
         chars_in     = chars_for_size(size_eff);
         src_in       = align_src(mask_value(req_block_value, size_eff), req_steps);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_busy_ff <= 1'b0;
         conv_full_ff <= 1'b0;
      end else begin
         conv_busy_ff <= conv_busy_in;
         conv_full_ff <= conv_full_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      chars_ff <= chars_in;
      src_ff   <= src_in;
   end

   // row of digit cells, least significant digit at index 0
   assign cell_ctl.clr  = req_xfer;
   assign cell_ctl.step = conv_busy_ff;
   assign carry[0]      = src_ff[SRC_W-1 -: GROUP_W];

   for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
      b58_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .carry_in   (carry[i]),
         .carry_out  (carry[i+1]),
         .digit_q    (cell_q[i]),
         .digit_next (cell_next[i])
      );
   end

   // align the row so the most significant used digit lands in the top output cell
   always_comb begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         row_vec[i*DIGIT_W +: DIGIT_W] = conv_full_ff ? cell_q[i] : cell_next[i];
      end
      row_shamt   = SHAMT_W'(DIGIT_W * (MAX_CHARS - int'(chars_ff)));
      row_aligned = row_vec << row_shamt;
   end

   // output row, emitted from the top cell
   assign out_ctl.load  = load_out;
   assign out_ctl.shift = rsp_xfer;

   for (genvar j = 0; j < MAX_CHARS; j++) begin : g_out
      if (j == 0) begin : g_first
         b58_out_cell u_out (
            .clock      (clock),
            .ctl        (out_ctl),
            .load_digit (row_aligned[j*DIGIT_W +: DIGIT_W]),
            .shift_in   ({DIGIT_W{1'b0}}),
            .digit_q    (out_q[j])
         );
      end else begin : g_rest
         b58_out_cell u_out (
            .clock      (clock),
            .ctl        (out_ctl),
            .load_digit (row_aligned[j*DIGIT_W +: DIGIT_W]),
            .shift_in   (out_q[j-1]),
            .digit_q    (out_q[j])
         );
      end
   end

   // character count and position for the block being sent
   always_comb begin
      out_rem_in = out_rem_ff;
      out_pos_in = out_pos_ff;
      if (load_out) begin
         out_rem_in = chars_ff;
         out_pos_in = '0;
      end else if (rsp_xfer) begin
         out_rem_in = out_rem_ff - POS_W'(1);
         out_pos_in = out_pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_rem_ff <= '0;
      end else begin
         out_rem_ff <= out_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pos_ff <= out_pos_in;
   end

   assign rsp_valid         = (out_rem_ff != '0);
   assign rsp_digit_char    = b58_char(out_q[MAX_CHARS-1]);
   assign rsp_char_position = out_pos_ff;
   assign rsp_last_char     = (out_rem_ff == POS_W'(1));

   // converter is either folding or holding a finished row, never both
   a_busy_full_excl: assert property (@(posedge clock) disable iff (reset)
      !(conv_busy_ff && conv_full_ff))
      else $error("converter busy and full together");

   // a folding converter always has a step left
   a_busy_steps: assert property (@(posedge clock) disable iff (reset)
      conv_busy_ff |-> (steps_ff != '0))
      else $error("converter busy with no step left");

   // the value always fits the row: nothing carries out of the top cell
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      conv_busy_ff |-> (carry[MAX_CHARS] == '0))
      else $error("carry out of the top digit cell");

   // an offered digit is a legal base-58 digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_q[MAX_CHARS-1] < DIGIT_W'(RADIX)))
      else $error("output digit out of range");

   // position plus remaining characters never exceeds a full block
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, out_pos_ff} + {1'b0, out_rem_ff}) <= (POS_W+1)'(MAX_CHARS)))
      else $error("character position past end of block");

endmodule
